/* design/bfha_pkg.sv */
`timescale 1ns / 1ps
// shared types and constants for the best-fit heap allocator
// no dependencies

package bfha_pkg;

    localparam int FIELD_W = 13;   // width of address, size and limit fields
    localparam int ROUND_W = 14;   // width of a request rounded up to the alignment

    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    localparam logic [1:0] STATUS_OK        = 2'd0;
    localparam logic [1:0] STATUS_OOM       = 2'd1;
    localparam logic [1:0] STATUS_NOT_FOUND = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ROUND,
        ST_WALK,
        ST_MERGE,
        ST_FIT,
        ST_SPLIT,
        ST_RESP
    } bfha_state_t;

    // number of low zero bits shared by both arguments, capped at 4
    function automatic int common_tz(input int a, input int b);
        int n;
        n = 0;
        for (int k = 0; k < 4; k++) begin
            if (((a >> k) & 1) == 0 && ((b >> k) & 1) == 0 && n == k) begin
                n = k + 1;
            end
        end
        return n;
    endfunction

endpackage

/* design/best_fit_heap_allocator.sv */
`timescale 1ns / 1ps
// best-fit heap allocator top level: header memory, block walk sequencer, outputs
// uses bfha_pkg and bfha_round
// the walk reads one block header per cycle from the header memory (one read port)
// one transaction at a time: the next is accepted in the cycle after the result
//   loads; the number of block headers walked reaches
//   ARENA_BYTES / (HEADER_BYTES + ALIGN_BYTES) at a full arena
// reset: synchronous active-low aresetn empties the arena (break pointer 0) and
//   sets arena_limit to 4096; the header memory itself is not cleared

module best_fit_heap_allocator import bfha_pkg::*; #(
    parameter int ARENA_BYTES  = 4096,
    parameter int HEADER_BYTES = 8,
    parameter int ALIGN_BYTES  = 8
) (
    input  logic               aclk,
    input  logic               aresetn,
    // configuration write channel
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [FIELD_W-1:0] cfg_arena_limit,
    // request channel
    input  logic               s_valid,
    output logic               s_ready,
    input  logic               s_cmd,
    input  logic [FIELD_W-1:0] s_request_bytes,
    input  logic [FIELD_W-1:0] s_user_address,
    // result channel
    output logic               m_valid,
    input  logic               m_ready,
    output logic [1:0]         m_status,
    output logic [FIELD_W-1:0] m_granted_address
);

    // block starts are multiples of this power of two, so it sets the memory grain
    localparam int GSH   = common_tz(HEADER_BYTES, ALIGN_BYTES);
    localparam int DEPTH = ((ARENA_BYTES - 1) >> GSH) + 1;
    localparam int IW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int AW    = $clog2(ARENA_BYTES + 1);
    localparam int CW    = ((AW > ROUND_W) ? AW : ROUND_W) + 1;

    localparam logic [CW-1:0] HDR   = CW'(HEADER_BYTES);
    localparam logic [CW-1:0] ALN   = CW'(ALIGN_BYTES);
    localparam logic [CW-1:0] ARENA = CW'(ARENA_BYTES);

    // header memory entry: free flag on top, user size below
    typedef struct packed {
        logic          free_flag;
        logic [AW-1:0] size;
    } hdr_t;

    hdr_t mem [DEPTH];
    hdr_t rd_data_reg;
    hdr_t wr_data;
    logic          wr_en;
    logic [CW-1:0] wr_start;
    logic [CW-1:0] rd_start;

    bfha_state_t state_reg, state_next;

    logic [FIELD_W-1:0] limit_reg;
    logic [CW-1:0] bp_reg, bp_next;
    logic          cmd_reg, cmd_next;
    logic [FIELD_W-1:0] addr_reg, addr_next;
    logic [CW-1:0] r_reg, r_next;
    logic [CW-1:0] cur_reg, cur_next;
    logic          found_reg, found_next;
    logic [CW-1:0] best_start_reg, best_start_next;
    logic [CW-1:0] best_size_reg, best_size_next;
    logic          prev_valid_reg, prev_valid_next;
    logic          prev_free_reg, prev_free_next;
    logic [CW-1:0] prev_start_reg, prev_start_next;
    logic [CW-1:0] prev_size_reg, prev_size_next;
    logic [CW-1:0] match_start_reg, match_start_next;
    logic [CW-1:0] match_size_reg, match_size_next;
    logic [CW-1:0] nxt_start_reg, nxt_start_next;
    logic [1:0]         status_reg, status_next;
    logic [FIELD_W-1:0] grant_reg, grant_next;
    logic               m_valid_reg, m_valid_next;
    logic [1:0]         m_status_reg, m_status_next;
    logic [FIELD_W-1:0] m_grant_reg, m_grant_next;

    logic               accept;
    logic               rnd_done;
    logic [ROUND_W-1:0] rnd_value;

    logic [CW-1:0] rd_size;
    logic [CW-1:0] next_start;
    logic          walk_end;
    logic          fit_here;
    logic          split;
    logic [CW-1:0] lim;
    logic [CW-1:0] need;
    logic          no_room;
    logic          next_free;
    logic [CW-1:0] merged_size;
    logic          resp_load;

    assign accept    = s_valid && s_ready;
    assign s_ready   = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign resp_load = (state_reg == ST_RESP) && (!m_valid_reg || m_ready);

    bfha_round #(
        .ALIGN_BYTES(ALIGN_BYTES)
    ) u_round (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (accept && s_cmd == CMD_ALLOC),
        .req     (s_request_bytes),
        .done    (rnd_done),
        .rounded (rnd_value)
    );

    // walk arithmetic on the header read out for cur_reg
    assign rd_size    = CW'(rd_data_reg.size);
    assign next_start = cur_reg + HDR + rd_size;
    assign walk_end   = cur_reg >= bp_reg;
    assign fit_here   = rd_data_reg.free_flag && rd_size >= r_reg &&
                        (!found_reg || rd_size < best_size_reg);

    // fit and append decisions
    assign split   = best_size_reg >= r_reg + HDR + ALN;
    assign lim     = (CW'(limit_reg) < ARENA) ? CW'(limit_reg) : ARENA;
    assign need    = HDR + r_reg;
    assign no_room = (bp_reg > lim) || (need > lim - bp_reg);

    // free: the neighbor after the match was read while the match was found
    assign next_free   = (nxt_start_reg < bp_reg) && rd_data_reg.free_flag;
    assign merged_size = match_size_reg + (next_free ? (HDR + rd_size) : '0);

    // read port follows the walk, points at offset 0 otherwise
    assign rd_start = (state_reg == ST_WALK) ? next_start : '0;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[IW'(wr_start >> GSH)] <= wr_data;
        end
        rd_data_reg <= mem[IW'(rd_start >> GSH)];
    end

    // write port
    always_comb begin
        wr_en    = 1'b0;
        wr_start = '0;
        wr_data  = '0;
        unique case (state_reg)
            ST_MERGE: begin
                wr_en = 1'b1;
                wr_data.free_flag = 1'b1;
                if (prev_valid_reg && prev_free_reg) begin
                    wr_start     = prev_start_reg;
                    wr_data.size = AW'(prev_size_reg + HDR + merged_size);
                end else begin
                    wr_start     = match_start_reg;
                    wr_data.size = AW'(merged_size);
                end
            end
            ST_FIT: begin
                wr_data.free_flag = 1'b0;
                if (found_reg) begin
                    wr_en        = 1'b1;
                    wr_start     = best_start_reg;
                    wr_data.size = split ? AW'(r_reg) : AW'(best_size_reg);
                end else begin
                    wr_en        = !no_room;
                    wr_start     = bp_reg;
                    wr_data.size = AW'(r_reg);
                end
            end
            ST_SPLIT: begin
                // leftover after the granted part becomes a free block
                wr_en             = 1'b1;
                wr_start          = best_start_reg + HDR + r_reg;
                wr_data.free_flag = 1'b1;
                wr_data.size      = AW'(best_size_reg - r_reg - HDR);
            end
            default: begin
            end
        endcase
    end

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    state_next = (s_cmd == CMD_ALLOC) ? ST_ROUND : ST_WALK;
                end
            end
            ST_ROUND: begin
                if (rnd_done) begin
                    state_next = ST_WALK;
                end
            end
            ST_WALK: begin
                if (cmd_reg == CMD_ALLOC) begin
                    if (walk_end) begin
                        state_next = ST_FIT;
                    end
                end else if (walk_end) begin
                    state_next = ST_RESP;
                end else if (cur_reg + HDR == CW'(addr_reg)) begin
                    state_next = ST_MERGE;
                end
            end
            ST_MERGE: state_next = ST_RESP;
            ST_FIT:   state_next = (found_reg && split) ? ST_SPLIT : ST_RESP;
            ST_SPLIT: state_next = ST_RESP;
            ST_RESP: begin
                if (resp_load) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // datapath
    always_comb begin
        bp_next          = bp_reg;
        cmd_next         = cmd_reg;
        addr_next        = addr_reg;
        r_next           = r_reg;
        cur_next         = cur_reg;
        found_next       = found_reg;
        best_start_next  = best_start_reg;
        best_size_next   = best_size_reg;
        prev_valid_next  = prev_valid_reg;
        prev_free_next   = prev_free_reg;
        prev_start_next  = prev_start_reg;
        prev_size_next   = prev_size_reg;
        match_start_next = match_start_reg;
        match_size_next  = match_size_reg;
        nxt_start_next   = nxt_start_reg;
        status_next      = status_reg;
        grant_next       = grant_reg;
        m_valid_next     = m_valid_reg && !m_ready;
        m_status_next    = m_status_reg;
        m_grant_next     = m_grant_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    cmd_next        = s_cmd;
                    addr_next       = s_user_address;
                    cur_next        = '0;
                    found_next      = 1'b0;
                    prev_valid_next = 1'b0;
                end
            end
            ST_ROUND: begin
                if (rnd_done) begin
                    r_next = CW'(rnd_value);
                end
            end
            ST_WALK: begin
                if (cmd_reg == CMD_ALLOC) begin
                    if (!walk_end) begin
                        cur_next = next_start;
                        if (fit_here) begin
                            found_next      = 1'b1;
                            best_start_next = cur_reg;
                            best_size_next  = rd_size;
                        end
                    end
                end else if (walk_end) begin
                    status_next = STATUS_NOT_FOUND;
                    grant_next  = '0;
                end else if (cur_reg + HDR == CW'(addr_reg)) begin
                    match_start_next = cur_reg;
                    match_size_next  = rd_size;
                    nxt_start_next   = next_start;
                end else begin
                    prev_valid_next = 1'b1;
                    prev_free_next  = rd_data_reg.free_flag;
                    prev_start_next = cur_reg;
                    prev_size_next  = rd_size;
                    cur_next        = next_start;
                end
            end
            ST_MERGE: begin
                status_next = STATUS_OK;
                grant_next  = '0;
            end
            ST_FIT: begin
                if (found_reg) begin
                    status_next = STATUS_OK;
                    grant_next  = FIELD_W'(best_start_reg + HDR);
                end else if (no_room) begin
                    status_next = STATUS_OOM;
                    grant_next  = '0;
                end else begin
                    status_next = STATUS_OK;
                    grant_next  = FIELD_W'(bp_reg + HDR);
                    bp_next     = bp_reg + need;
                end
            end
            ST_RESP: begin
                if (resp_load) begin
                    m_valid_next  = 1'b1;
                    m_status_next = status_reg;
                    m_grant_next  = grant_reg;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            bp_reg      <= '0;
            limit_reg   <= FIELD_W'(4096);
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            bp_reg      <= bp_next;
            m_valid_reg <= m_valid_next;
            if (cfg_valid && cfg_ready) begin
                limit_reg <= cfg_arena_limit;
            end
        end
        cmd_reg         <= cmd_next;
        addr_reg        <= addr_next;
        r_reg           <= r_next;
        cur_reg         <= cur_next;
        found_reg       <= found_next;
        best_start_reg  <= best_start_next;
        best_size_reg   <= best_size_next;
        prev_valid_reg  <= prev_valid_next;
        prev_free_reg   <= prev_free_next;
        prev_start_reg  <= prev_start_next;
        prev_size_reg   <= prev_size_next;
        match_start_reg <= match_start_next;
        match_size_reg  <= match_size_next;
        nxt_start_reg   <= nxt_start_next;
        status_reg      <= status_next;
        grant_reg       <= grant_next;
        m_status_reg    <= m_status_next;
        m_grant_reg     <= m_grant_next;
    end

    assign m_valid           = m_valid_reg;
    assign m_status          = m_status_reg;
    assign m_granted_address = m_grant_reg;

    // break pointer stays inside the arena
    a_bp_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        bp_reg <= ARENA)
        else $error("break pointer past arena");

    // the rounding unit only answers while the sequencer waits for it
    a_round_owner: assert property (@(posedge aclk) disable iff (!aresetn)
        rnd_done |-> state_reg == ST_ROUND)
        else $error("rounding result outside round state");

    // a split only follows a granted fit
    a_split_src: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_SPLIT |-> $past(state_reg) == ST_FIT && found_reg)
        else $error("split without a fit");

    // a free never grants an address
    a_free_grant: assert property (@(posedge aclk) disable iff (!aresetn)
        resp_load && cmd_reg == CMD_FREE |=> m_granted_address == '0)
        else $error("free returned an address");

    // results only carry defined status codes
    a_status_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_status == STATUS_OK || m_status == STATUS_OOM ||
                     m_status == STATUS_NOT_FOUND))
        else $error("undefined status code");

endmodule

/* design/bfha_round.sv */
`timescale 1ns / 1ps
// rounds a request up to a multiple of the alignment, alignment as minimum
// two register stages, reciprocal multiply; uses bfha_pkg

module bfha_round import bfha_pkg::*; #(
    parameter int ALIGN_BYTES = 8
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               start,
    input  logic [FIELD_W-1:0] req,
    output logic               done,
    output logic [ROUND_W-1:0] rounded
);

    localparam int SHIFT = 18;
    localparam int MULT  = ((1 << SHIFT) + ALIGN_BYTES - 1) / ALIGN_BYTES;
    localparam int MW    = SHIFT + 1;
    localparam int PW    = ROUND_W + MW;
    localparam logic [ROUND_W-1:0] ALIGN_C = ROUND_W'(ALIGN_BYTES);

    logic               v1_reg, v2_reg;
    logic [ROUND_W-1:0] q_reg, q_next;
    logic [ROUND_W-1:0] r_reg, r_next;
    logic               small_reg;
    logic [ROUND_W-1:0] biased;
    logic [PW-1:0]      prod;
    logic [2*ROUND_W-1:0] back;

    assign biased = ROUND_W'(req) + ALIGN_C - ROUND_W'(1);
    assign prod   = PW'(biased) * PW'(MULT);
    assign q_next = prod[SHIFT +: ROUND_W];
    assign back   = (2*ROUND_W)'(q_reg) * (2*ROUND_W)'(ALIGN_C);
    assign r_next = small_reg ? ALIGN_C : back[ROUND_W-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end else begin
            v1_reg <= start;
            v2_reg <= v1_reg;
        end
        q_reg     <= q_next;
        small_reg <= ROUND_W'(req) < ALIGN_C;
        r_reg     <= r_next;
    end

    assign done    = v2_reg;
    assign rounded = r_reg;

endmodule
